[sv/cmrb_pkg.sv]
// Package for the CAN message record buffer: sizes, request kinds, header layout.
// No dependencies; used by the interfaces, the RAM wrapper users and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cmrb_pkg;

    // Store depth in messages
    localparam int CAPACITY = 256;

    localparam int ADDR_W = $clog2(CAPACITY);
    // Write position must also hold CAPACITY itself (left there by linear fill)
    localparam int POS_W  = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 8;
    localparam int ID_W    = 29;
    localparam int FLAGS_W = 8;
    localparam int DLC_W   = 4;
    localparam int DATA_W  = 64;
    localparam int FILL_W  = 9;

    // Wide enough for index + position and for the range compares
    localparam int SUM_W = ((POS_W > IDX_W) ? POS_W : IDX_W) + 1;

    localparam logic [POS_W-1:0]  CAP_POS  = POS_W'(CAPACITY);
    localparam logic [SUM_W-1:0]  CAP_SUM  = SUM_W'(CAPACITY);
    localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Result status
    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Header word as stored: dlc in the top bits, then flags, then id
    typedef struct packed {
        logic [DLC_W-1:0]   dlc;
        logic [FLAGS_W-1:0] flags;
        logic [ID_W-1:0]    id;
    } t_header;

    localparam int HDR_W = $bits(t_header);

endpackage

`default_nettype wire

[sv/cmrb_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on cmrb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cmrb_req_if
    import cmrb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   index;
    logic [ID_W-1:0]    msg_id;
    logic [FLAGS_W-1:0] msg_flags;
    logic [DLC_W-1:0]   msg_dlc;
    logic [DATA_W-1:0]  msg_data;

    modport source (output valid, kind, index, msg_id, msg_flags, msg_dlc, msg_data,
                    input ready);
    modport sink   (input valid, kind, index, msg_id, msg_flags, msg_dlc, msg_data,
                    output ready);
endinterface

interface cmrb_rsp_if
    import cmrb_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               status;
    logic [ID_W-1:0]    out_id;
    logic [FLAGS_W-1:0] out_flags;
    logic [DLC_W-1:0]   out_dlc;
    logic [DATA_W-1:0]  out_data;
    logic [FILL_W-1:0]  fill_count;

    modport source (output valid, status, out_id, out_flags, out_dlc, out_data, fill_count,
                    input ready);
    modport sink   (input valid, status, out_id, out_flags, out_dlc, out_data, fill_count,
                    output ready);
endinterface

`default_nettype wire

[sv/cmrb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cmrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[sv/can_message_record_buffer.sv]
// Top level of the CAN message record buffer: pointer logic, two message RAMs,
// result stage. Depends on cmrb_pkg, cmrb_req_if / cmrb_rsp_if and cmrb_ram.
//
// Channel   Dir  Handshake      Moves
// i_req     in   valid/ready    one request: kind, index, message fields
// o_rsp     out  valid/ready    one result per request: status, message, fill count
// i_cfg_*   in   write enable   overwrite_mode bit, taken on any enabled edge
//
// Flow: a request is accepted, its RAM read and pointer update happen at that
// edge, and its result moves from the read stage into the output register when
// that stage advances. With the result side ready, one request per cycle is
// sustained; the read stage holds the data of the registered RAM read port.
// Reset: clears the write position, the wrapped mark, the mode and the valid
// bits. The RAMs are not cleared; entries never written are never read in range.
// Stalls: the read stage holds while the output register is full and not taken;
// i_req.ready drops only then.
`timescale 1ns / 1ps
`default_nettype none

module can_message_record_buffer
    import cmrb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    cmrb_req_if.sink   i_req,
    cmrb_rsp_if.source o_rsp
);

    // ---------------------------------------------------------------- state
    logic             r_overwrite;
    logic [POS_W-1:0] r_wpos, n_wpos;
    logic             r_wrapped, n_wrapped;

    // read stage: RAM data arrives here
    logic              r_s1_valid;
    logic              r_s1_status;
    logic              r_s1_rd;      // read in range: pass RAM data through
    logic [FILL_W-1:0] r_s1_fill;
    logic              n_status;
    logic              n_rd;
    logic [FILL_W-1:0] n_fill;

    // output register
    logic               r_o_valid;
    logic               r_o_status;
    logic [ID_W-1:0]    r_o_id;
    logic [FLAGS_W-1:0] r_o_flags;
    logic [DLC_W-1:0]   r_o_dlc;
    logic [DATA_W-1:0]  r_o_data;
    logic [FILL_W-1:0]  r_o_fill;

    // RAM ports
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    t_header           wr_hdr;
    t_header           rd_hdr;
    logic [DATA_W-1:0] rd_data;

    logic accept;
    logic s1_adv;

    // --------------------------------------------------------- handshakes
    assign s1_adv      = r_s1_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign accept      = i_req.valid && i_req.ready;

    // ------------------------------------------------- request decode
    logic [ADDR_W-1:0] pos_eff;   // full position counts as entry 0 on overwrite
    logic [POS_W-1:0]  pos_inc;
    logic [SUM_W-1:0]  idx_ext;
    logic [SUM_W-1:0]  slot_sum;
    logic              pos_full;

    assign pos_full = (r_wpos >= CAP_POS);
    assign pos_eff  = pos_full ? '0 : r_wpos[ADDR_W-1:0];
    assign pos_inc  = POS_W'(pos_eff) + POS_W'(1);
    assign idx_ext  = SUM_W'(i_req.index);

    always_comb begin
        n_wpos    = r_wpos;
        n_wrapped = r_wrapped;
        n_status  = STATUS_DONE;
        n_rd      = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = pos_eff;
        mem_raddr = i_req.index[ADDR_W-1:0];
        slot_sum  = idx_ext + SUM_W'(pos_eff);
        if (slot_sum >= CAP_SUM) begin
            slot_sum = slot_sum - CAP_SUM;
        end

        case (i_req.kind)
            KIND_WRITE: begin
                if (r_overwrite) begin
                    mem_we = accept;
                    if (pos_full) begin
                        n_wrapped = 1'b1;
                    end
                    if (pos_inc >= CAP_POS) begin
                        n_wpos    = '0;
                        n_wrapped = 1'b1;
                    end else begin
                        n_wpos = pos_inc;
                    end
                end else if (pos_full) begin
                    n_status = STATUS_REJECT;
                end else begin
                    mem_we = accept;
                    n_wpos = r_wpos + POS_W'(1);
                end
            end
            KIND_READ: begin
                if (r_overwrite && r_wrapped) begin
                    // count from the oldest entry, which sits at the write position
                    n_rd      = (idx_ext < CAP_SUM);
                    mem_raddr = slot_sum[ADDR_W-1:0];
                end else begin
                    n_rd = (idx_ext < SUM_W'(r_wpos));
                end
                mem_re   = accept && n_rd;
                n_status = n_rd ? STATUS_DONE : STATUS_REJECT;
            end
            KIND_CLEAR: begin
                n_wpos    = '0;
                n_wrapped = 1'b0;
            end
            default: begin
                n_status = STATUS_REJECT;
            end
        endcase

        n_fill = (r_overwrite && n_wrapped) ? CAP_FILL : FILL_W'(n_wpos);
    end

    assign wr_hdr.id    = i_req.msg_id;
    assign wr_hdr.flags = i_req.msg_flags;
    assign wr_hdr.dlc   = i_req.msg_dlc;

    // ------------------------------------------------------------ memories
    cmrb_ram #(
        .WIDTH (HDR_W),
        .DEPTH (CAPACITY)
    ) u_header_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_hdr),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_hdr)
    );

    cmrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_req.msg_data),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // ------------------------------------------------------- control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overwrite <= 1'b0;
            r_wpos      <= '0;
            r_wrapped   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_overwrite <= i_cfg_wdata;
            end
            if (accept) begin
                r_wpos    <= n_wpos;
                r_wrapped <= n_wrapped;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------ payload regs
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_status;
            r_s1_rd     <= n_rd;
            r_s1_fill   <= n_fill;
        end
        if (s1_adv) begin
            r_o_status <= r_s1_status;
            r_o_fill   <= r_s1_fill;
            // message fields are zero unless a read hit
            r_o_id     <= r_s1_rd ? rd_hdr.id    : '0;
            r_o_flags  <= r_s1_rd ? rd_hdr.flags : '0;
            r_o_dlc    <= r_s1_rd ? rd_hdr.dlc   : '0;
            r_o_data   <= r_s1_rd ? rd_data      : '0;
        end
    end

    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.out_id     = r_o_id;
    assign o_rsp.out_flags  = r_o_flags;
    assign o_rsp.out_dlc    = r_o_dlc;
    assign o_rsp.out_data   = r_o_data;
    assign o_rsp.fill_count = r_o_fill;

endmodule

`default_nettype wire
